### rtl/csrb_pkg.sv
`timescale 1ns / 1ps
// csrb_pkg: shared widths, types and register codes for the shade ramp builder.
// No dependencies; imported by every rtl module of the block but csrb_checker.
package csrb_pkg;

  localparam int DATA_W     = 16;              // color channel width
  localparam int NCH        = 3;               // red, green, blue
  localparam int MAX_SHADES = 64;
  localparam int IDX_W      = $clog2(MAX_SHADES);
  localparam int CNT_W      = 7;               // shade_count register width
  localparam int DAC_W      = 5;               // dac_bits register width
  localparam int SH_W       = 5;               // shift 0..16
  localparam int CFG_W      = 7;               // widest register
  localparam int DEN_W      = 8;               // divisor 4n-2, up to 254
  localparam int NUM_W      = 20;              // dividend 4r+2n-1, zero padded
  localparam int DIV_BITS   = 4;               // quotient bits per stage
  localparam int DIV_STAGES = NUM_W / DIV_BITS;
  localparam int Q_W        = 18;              // quotient fits in 18 bits
  localparam int PROD_W     = Q_W + IDX_W;

  // register indexes
  localparam logic REG_SHADE_COUNT = 1'b0;
  localparam logic REG_DAC_BITS    = 1'b1;

  // derived configuration, held while items are in flight
  typedef struct packed {
    logic [CNT_W-1:0] n;      // effective shade count 1..MAX_SHADES
    logic [IDX_W-1:0] nm1;    // n - 1
    logic [DEN_W-1:0] den;    // 4n - 2
    logic [SH_W-1:0]  sh;     // 16 - dac_bits
  } cfg_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [NCH-1:0][DATA_W-1:0] base;
    logic [NCH-1:0][DATA_W-1:0] r;
    div_t [NCH-1:0]             div;
    logic                       last;
  } pipe_t;

  typedef struct packed {
    logic [NCH-1:0][DATA_W-1:0] base;
    logic [NCH-1:0][DATA_W-1:0] step;
    logic                       last;
  } load_t;

endpackage

### rtl/csrb_div_stage.sv
`timescale 1ns / 1ps
// csrb_div_stage: one register stage of the restoring divider, DIV_BITS
// quotient bits per channel per stage. Depends on csrb_pkg.
module csrb_div_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [csrb_pkg::DEN_W-1:0] den,
  input  logic                  in_valid,
  input  csrb_pkg::pipe_t       in_item,
  output logic                  out_valid,
  output csrb_pkg::pipe_t       out_item
);
  import csrb_pkg::*;

  pipe_t item_next;

  always_comb begin
    logic [DEN_W:0] tmp;
    div_t           dv;
    item_next = in_item;
    for (int c = 0; c < NCH; c++) begin
      dv = in_item.div[c];
      for (int b = 0; b < DIV_BITS; b++) begin
        tmp    = {dv.rem, dv.num[NUM_W-1]};
        dv.num = {dv.num[NUM_W-2:0], 1'b0};
        if (tmp >= {1'b0, den}) begin
          dv.rem = DEN_W'(tmp - {1'b0, den});
          dv.quo = {dv.quo[NUM_W-2:0], 1'b1};
        end else begin
          dv.rem = tmp[DEN_W-1:0];
          dv.quo = {dv.quo[NUM_W-2:0], 1'b0};
        end
      end
      item_next.div[c] = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

### rtl/csrb_step_pipe.sv
`timescale 1ns / 1ps
// csrb_step_pipe: per-channel step computation, truncation, divider stages,
// clamp and rescale. Depends on csrb_pkg and csrb_div_stage.
module csrb_step_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  csrb_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  input  logic [csrb_pkg::NCH-1:0][csrb_pkg::DATA_W-1:0] in_base,
  input  logic                  in_last,
  output logic                  out_valid,
  output csrb_pkg::load_t       out_load
);
  import csrb_pkg::*;

  logic  [DIV_STAGES:0] vld;
  pipe_t                stg [DIV_STAGES+1];
  pipe_t                front_next;
  logic                 front_valid;
  pipe_t                front_item;
  logic                 cap_valid;
  pipe_t                cap_item;
  logic [NCH-1:0]       cap_gt;
  logic [NCH-1:0]       gt_next;
  load_t                load_next;

  // front: truncate to DAC width and form 4r + 2n - 1
  always_comb begin
    logic [DATA_W-1:0] r;
    front_next      = '0;
    front_next.base = in_base;
    front_next.last = in_last;
    for (int c = 0; c < NCH; c++) begin
      r = in_base[c] >> cfg.sh;
      front_next.r[c]       = r;
      front_next.div[c].num = NUM_W'({r, 2'b00}) + NUM_W'({cfg.n, 1'b0}) - NUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (en) begin
      front_valid <= in_valid;
    end
    if (en) begin
      front_item <= front_next;
    end
  end

  assign vld[0] = front_valid;
  assign stg[0] = front_item;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    csrb_div_stage u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .den      (cfg.den),
      .in_valid (vld[s]),
      .in_item  (stg[s]),
      .out_valid(vld[s+1]),
      .out_item (stg[s+1])
    );
  end

  // rounded quotient may exceed floor(r/(n-1)) by one at most
  always_comb begin
    logic [PROD_W-1:0] prod;
    gt_next = '0;
    for (int c = 0; c < NCH; c++) begin
      prod = PROD_W'(stg[DIV_STAGES].div[c].quo[Q_W-1:0]) * PROD_W'(cfg.nm1);
      gt_next[c] = prod > PROD_W'(stg[DIV_STAGES].r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (en) begin
      cap_valid <= vld[DIV_STAGES];
    end
    if (en) begin
      cap_item <= stg[DIV_STAGES];
      cap_gt   <= gt_next;
    end
  end

  always_comb begin
    logic [Q_W-1:0] q;
    load_next      = '0;
    load_next.base = cap_item.base;
    load_next.last = cap_item.last;
    for (int c = 0; c < NCH; c++) begin
      q = cap_item.div[c].quo[Q_W-1:0] - Q_W'(cap_gt[c]);
      if (cfg.nm1 == '0) begin
        q = '0;   // single-entry ramp
      end
      load_next.step[c] = DATA_W'(q << cfg.sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cap_valid;
    end
    if (en) begin
      out_load <= load_next;
    end
  end

endmodule

### rtl/csrb_ramp_gen.sv
`timescale 1ns / 1ps
// csrb_ramp_gen: output register and shade sequencer, one shade per transaction.
// Depends on csrb_pkg.
module csrb_ramp_gen (
  input  logic                  clk,
  input  logic                  rst,
  input  csrb_pkg::cfg_t        cfg,
  input  logic                  ld_valid,
  input  csrb_pkg::load_t       ld,
  output logic                  ld_take,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [csrb_pkg::NCH-1:0][csrb_pkg::DATA_W-1:0] out_color,
  output logic [csrb_pkg::IDX_W-1:0] out_index,
  output logic                  out_last_ramp,
  output logic                  out_end_table
);
  import csrb_pkg::*;

  logic                       busy;
  logic [NCH-1:0][DATA_W-1:0] acc;
  logic [NCH-1:0][DATA_W-1:0] step;
  logic [IDX_W-1:0]           idx;
  logic                       last_color;
  logic                       at_last;

  assign at_last = (idx == cfg.nm1);
  assign ld_take = ld_valid && (!busy || (out_ready && at_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ld_take) begin
      busy <= 1'b1;
    end else if (out_ready && at_last) begin
      busy <= 1'b0;
    end
    if (ld_take) begin
      acc        <= ld.base;
      step       <= ld.step;
      idx        <= '0;
      last_color <= ld.last;
    end else if (busy && out_ready) begin
      for (int c = 0; c < NCH; c++) begin
        acc[c] <= acc[c] - step[c];
      end
      idx <= idx + IDX_W'(1);
    end
  end

  assign out_valid     = busy;
  assign out_color     = acc;
  assign out_index     = idx;
  assign out_last_ramp = at_last;
  assign out_end_table = at_last && last_color;

endmodule

### rtl/color_shade_ramp_builder.sv
`timescale 1ns / 1ps
// Shade ramp builder top level: config registers, step pipeline, ramp sequencer.
// Depends on csrb_pkg, csrb_step_pipe and csrb_ramp_gen.
// Throughput: one shade per cycle while m_tready is high; a base color yields
//   shade_count shades (clamped to 1..64), issued by the ramp sequencer.
// The 8-stage step pipeline takes one color per unstalled cycle; it stalls as a whole.
// Reset (synchronous rst): pipeline and output emptied, shade_count = 16, dac_bits = 8.
module color_shade_ramp_builder (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // base_red[15:0], base_green[31:16], base_blue[47:32]
  input  logic        s_tlast,   // is_last_color
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // shade_red[15:0], shade_green[31:16],
                                 // shade_blue[47:32], shade_index[53:48], zero[55:54]
  output logic        m_tlast,   // last_of_ramp
  output logic        m_tuser    // end_of_table
);
  import csrb_pkg::*;

  cfg_t cfg;
  logic [CNT_W-1:0] n_new;
  logic [DAC_W-1:0] dac_new;

  // Config is kept in derived form: effective count, n-1, divisor 4n-2 and
  // the truncation shift. Users must write only while the block is idle (unenforced).
  always_comb begin
    n_new = cfg_data[CNT_W-1:0];
    if (n_new == '0) begin
      n_new = CNT_W'(1);
    end else if (n_new > CNT_W'(MAX_SHADES)) begin
      n_new = CNT_W'(MAX_SHADES);
    end
    dac_new = cfg_data[DAC_W-1:0];
    if (dac_new > DAC_W'(DATA_W)) begin
      dac_new = DAC_W'(DATA_W);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.n   <= CNT_W'(16);
      cfg.nm1 <= IDX_W'(15);
      cfg.den <= DEN_W'(62);
      cfg.sh  <= SH_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHADE_COUNT: begin
          cfg.n   <= n_new;
          cfg.nm1 <= IDX_W'(n_new - CNT_W'(1));
          cfg.den <= DEN_W'({n_new, 2'b00} - 9'd2);
        end
        REG_DAC_BITS: begin
          cfg.sh <= SH_W'(DATA_W) - SH_W'(dac_new);
        end
        default: begin
        end
      endcase
    end
  end

  // step pipeline advances whenever its last stage is empty or drained
  logic  pipe_valid;
  load_t pipe_load;
  logic  ld_take;
  logic  advance;
  logic [NCH-1:0][DATA_W-1:0] in_base;
  logic [NCH-1:0][DATA_W-1:0] out_color;
  logic [IDX_W-1:0]           out_index;

  assign advance  = !pipe_valid || ld_take;
  assign s_tready = advance;
  assign in_base  = s_tdata;

  csrb_step_pipe u_step (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_base  (in_base),
    .in_last  (s_tlast),
    .out_valid(pipe_valid),
    .out_load (pipe_load)
  );

  // output register doubles as the ramp state; the next color loads on the
  // same edge the final shade of the current one is taken
  csrb_ramp_gen u_ramp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ld_valid     (pipe_valid),
    .ld           (pipe_load),
    .ld_take      (ld_take),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_color    (out_color),
    .out_index    (out_index),
    .out_last_ramp(m_tlast),
    .out_end_table(m_tuser)
  );

  assign m_tdata = {2'b00, out_index, out_color};

endmodule

### rtl/csrb_checker.sv
`timescale 1ns / 1ps
// csrb_checker: port-level assertions for the shade ramp builder, bound to
// the top level. Depends on color_shade_ramp_builder ports only.
module csrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [6:0]  cfg_data,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output changed while stalled");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[53:48] == $past(m_tdata[53:48]) + 6'd1))
    else $error("shade index did not advance within a ramp");

  a_ramp_restart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[53:48] == 6'd0))
    else $error("new ramp did not start at index zero");

  a_end_in_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("end of table outside the last shade of a ramp");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind color_shade_ramp_builder csrb_checker u_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for color_shade_ramp_builder.
// Uses csrb_pkg for widths and register indexes; directed table, then random
// phases, with every shade compared against a ramp predictor kept in the bench.
module tb_top;
  import csrb_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no transaction before giving up
  localparam int TAIL_CYCLES = 20;    // margin after the final drain, to catch stray shades
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 26;
  localparam int MAX_REPORTS = 50;

  // one expected shade, field for field as it leaves the block
  typedef struct {
    logic [DATA_W-1:0] red;
    logic [DATA_W-1:0] green;
    logic [DATA_W-1:0] blue;
    logic [IDX_W-1:0]  index;
    logic              last_of_ramp;
    logic              end_of_table;
  } shade_t;

  // directed row: register setting, base color, and optionally a hand-worked
  // per-channel step that replaces the predictor for that color
  typedef struct packed {
    logic [CNT_W-1:0]  cnt;
    logic [DAC_W-1:0]  dac;
    logic [DATA_W-1:0] red;
    logic [DATA_W-1:0] green;
    logic [DATA_W-1:0] blue;
    logic              last;
    logic              typed;
    logic [DATA_W-1:0] step;
  } color_row_t;

  localparam int N_DIR = 19;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_SHADE_COUNT;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // base_red[15:0], base_green[31:16], base_blue[47:32]
  logic        s_tlast = 1'b0; // is_last_color
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;        // shade_red[15:0], shade_green[31:16],
                               // shade_blue[47:32], shade_index[53:48], zero[55:54]
  logic        m_tlast;        // last_of_ramp
  logic        m_tuser;        // end_of_table

  // hand-worked step travels with the color, so the monitor sees it at the
  // same edge as the input transaction
  logic              typed_valid = 1'b0;
  logic [DATA_W-1:0] typed_step = '0;

  // shadow copy of the registers, as the block holds them after reset
  logic [CNT_W-1:0] cnt_reg = 7'd16;
  logic [DAC_W-1:0] dac_reg = 5'd8;

  shade_t shade_q[$];
  bit     calm = 1'b0;      // no idling on either side while set
  int     ready_hold = 0;
  int     stall_cycles = 0;
  int     errors = 0;
  int     colors_in = 0;
  int     shades_out = 0;
  int     settings = 1;

  color_row_t dir_rows [N_DIR] = '{
    // reset setting: full scale works out to 255 -> step 16 -> 16 << 8
    '{7'd16,  5'd8,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'h1000},
    '{7'd16,  5'd8,  16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000},
    '{7'd16,  5'd8,  16'h1234, 16'h8000, 16'h00FF, 1'b0, 1'b0, 16'h0000},
    '{7'd16,  5'd8,  16'h0100, 16'h00FF, 16'h8001, 1'b1, 1'b0, 16'h0000},
    // a single entry is just the base color
    '{7'd1,   5'd8,  16'hFFFF, 16'h0000, 16'h8000, 1'b1, 1'b1, 16'h0000},
    '{7'd1,   5'd8,  16'h1234, 16'h5678, 16'h9ABC, 1'b0, 1'b1, 16'h0000},
    // zero count behaves as one
    '{7'd0,   5'd8,  16'hABCD, 16'hFFFF, 16'h0001, 1'b1, 1'b1, 16'h0000},
    // longest ramp, no truncation
    '{7'd64,  5'd16, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{7'd64,  5'd16, 16'h0001, 16'h003F, 16'h0040, 1'b0, 1'b0, 16'h0000},
    '{7'd64,  5'd16, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000},
    // count above the maximum saturates to 64
    '{7'd127, 5'd16, 16'hFFFF, 16'h8000, 16'h0001, 1'b1, 1'b0, 16'h0000},
    '{7'd65,  5'd1,  16'hFFFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 16'h0000},
    // zero DAC bits: everything truncates away, flat ramp
    '{7'd2,   5'd0,  16'hFFFF, 16'h1234, 16'h0001, 1'b1, 1'b1, 16'h0000},
    '{7'd64,  5'd0,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 16'h0000},
    // DAC bits above 16 saturate, then dac_bits of 16 and 4
    '{7'd2,   5'd31, 16'hFFFF, 16'h0000, 16'h5555, 1'b0, 1'b0, 16'h0000},
    '{7'd2,   5'd31, 16'hAAAA, 16'h5555, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{7'd3,   5'd17, 16'h0003, 16'h0002, 16'h0001, 1'b0, 1'b0, 16'h0000},
    '{7'd2,   5'd16, 16'h0001, 16'h0002, 16'h0003, 1'b1, 1'b0, 16'h0000},
    '{7'd5,   5'd4,  16'hF000, 16'h0FFF, 16'h8888, 1'b0, 1'b0, 16'h0000}
  };

  color_shade_ramp_builder DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Per-channel full-scale step: truncate to the DAC width, divide by N - 0.5
  // rounding half up, clamp so the darkest entry stays at or above zero.
  function automatic logic [DATA_W-1:0] ramp_step(input logic [DATA_W-1:0] base,
                                                 input int n, input int sh);
    int r;
    int q;
    int cap;
    r = int'(base) >> sh;
    if (n <= 1) return '0;
    q   = (4 * r + 2 * n - 1) / (4 * n - 2);
    cap = r / (n - 1);
    if (q > cap) q = cap;
    return DATA_W'(q << sh);
  endfunction

  // Expand one accepted base color into its whole ramp of expected shades.
  task automatic load_ramp();
    shade_t            e;
    int                n;
    int                sh;
    logic [DATA_W-1:0] base [3];
    logic [DATA_W-1:0] step [3];
    n  = int'(cnt_reg);
    if (n < 1) n = 1;
    if (n > MAX_SHADES) n = MAX_SHADES;
    sh = (int'(dac_reg) > 16) ? 0 : 16 - int'(dac_reg);
    base[0] = s_tdata[15:0];
    base[1] = s_tdata[31:16];
    base[2] = s_tdata[47:32];
    for (int c = 0; c < 3; c++) begin
      step[c] = typed_valid ? typed_step : ramp_step(base[c], n, sh);
    end
    for (int k = 0; k < n; k++) begin
      e.red          = DATA_W'(int'(base[0]) - k * int'(step[0]));
      e.green        = DATA_W'(int'(base[1]) - k * int'(step[1]));
      e.blue         = DATA_W'(int'(base[2]) - k * int'(step[2]));
      e.index        = IDX_W'(k);
      e.last_of_ramp = (k == n - 1);
      e.end_of_table = (k == n - 1) && s_tlast;
      shade_q.push_back(e);
    end
  endtask

  task automatic report(input string field, input logic [DATA_W-1:0] want,
                        input logic [DATA_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $error("shade %0d: %s expected 0x%0h, got 0x%0h", shades_out, field, want, got);
  endtask

  task automatic check_shade();
    shade_t e;
    if (shade_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $error("shade transaction with nothing expected: 0x%0h", m_tdata);
      return;
    end
    e = shade_q.pop_front();
    if (m_tdata[15:0] !== e.red)         report("shade_red", e.red, m_tdata[15:0]);
    if (m_tdata[31:16] !== e.green)      report("shade_green", e.green, m_tdata[31:16]);
    if (m_tdata[47:32] !== e.blue)       report("shade_blue", e.blue, m_tdata[47:32]);
    if (m_tdata[53:48] !== e.index)      report("shade_index", e.index, m_tdata[53:48]);
    if (m_tlast !== e.last_of_ramp)      report("last_of_ramp", e.last_of_ramp, m_tlast);
    if (m_tuser !== e.end_of_table)      report("end_of_table", e.end_of_table, m_tuser);
    shades_out++;
  endtask

  // Monitor: both handshakes sampled at the same edge, input side first, so a
  // color's ramp is queued long before its first shade can appear. The
  // watchdog lives here too, counting edges with no transaction at all.
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        load_ramp();
        colors_in++;
      end
      if (m_tvalid && m_tready) check_shade();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d shades outstanding",
                 STALL_LIMIT, shade_q.size());
        $display("[color_shade_ramp_builder] ERROR");
        $finish;
      end
    end
  end

  // Output back-pressure: random stalls of random length unless calm.
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 4) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // One base color transaction, with an occasional idle gap of random length ahead of it.
  task automatic send_color(input logic [DATA_W-1:0] red, input logic [DATA_W-1:0] green,
                            input logic [DATA_W-1:0] blue, input logic last,
                            input logic typed, input logic [DATA_W-1:0] step);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= {blue, green, red};
    s_tlast     <= last;
    typed_valid <= typed;
    typed_step  <= step;
    do @(posedge clk); while (!s_tready);
  endtask

  // Registers change only with the block drained: every color yields at least
  // one shade, so an empty queue means nothing is left in flight. The first
  // edge lets the monitor queue a color accepted at the edge just passed.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (shade_q.size() != 0) @(posedge clk);
  endtask

  task automatic apply_config(input logic [CNT_W-1:0] cnt, input logic [DAC_W-1:0] dac);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHADE_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    cnt_reg    = cnt;
    cfg_index <= REG_DAC_BITS;
    cfg_data  <= 7'(dac);
    @(posedge clk);
    dac_reg    = dac;
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // Random channel value, biased toward the rails and coarse steps.
  function automatic logic [DATA_W-1:0] rand_chan();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(0, 255));
      3:       return DATA_W'($urandom_range(0, 255) << 8);
      default: return DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [CNT_W-1:0] cnt;
    logic [DAC_W-1:0] dac;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table; the first rows run on the reset setting
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cnt != cnt_reg || dir_rows[i].dac != dac_reg) begin
        drain();
        apply_config(dir_rows[i].cnt, dir_rows[i].dac);
      end
      send_color(dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue,
                 dir_rows[i].last, dir_rows[i].typed, dir_rows[i].step);
    end

    // random phases: mostly short ramps, with the corner settings mixed in;
    // the final phase runs with no idling at all
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case ($urandom_range(0, 9))
        0:       cnt = 7'd0;
        1:       cnt = 7'(MAX_SHADES);
        2:       cnt = 7'($urandom_range(65, 127));
        3:       cnt = 7'd1;
        default: cnt = 7'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 7))
        0:       dac = 5'd0;
        1:       dac = 5'd16;
        2:       dac = 5'($urandom_range(17, 31));
        default: dac = 5'($urandom_range(1, 16));
      endcase
      apply_config(cnt, dac);
      calm <= (p == RAND_PHASES - 1) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_color(rand_chan(), rand_chan(), rand_chan(),
                   $urandom_range(0, 3) == 0, 1'b0, '0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shade_q.size() != 0) begin
      errors++;
      $error("%0d expected shades never arrived", shade_q.size());
    end

    $display("covered %0d base colors over %0d register settings, %0d shades compared",
             colors_in, settings, shades_out);
    $display("directed corners plus %0d random phases, %0d mismatches",
             RAND_PHASES, errors);
    if (errors == 0) begin
      $display("[color_shade_ramp_builder] OK");
    end else begin
      $display("[color_shade_ramp_builder] ERROR");
    end
    $finish;
  end

endmodule
